// File: rtl/core/array_list_insert_delete_macros.svh
// Assertion macros shared by the ordered-list RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ARRAY_LIST_INSERT_DELETE_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ALD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered list: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ALD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered list: next-cycle check failed");

`endif

// File: rtl/core/ald_pkg.sv
// Types and codes of the ordered list: operation, status and cell command codes.
// No dependencies; imported by ald_cell and array_list_insert_delete.
package ald_pkg;

	// operation codes of an input item
	localparam logic [2:0] FUNC_INSERT = 3'd0;
	localparam logic [2:0] FUNC_DELETE = 3'd1;
	localparam logic [2:0] FUNC_READ   = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_DUMP   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// per-cycle command broadcast to every cell
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_DEL  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	localparam int DATA_W = 32;
	localparam int TDATA_W = 40;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] position;
	} cell_cmd_t;

endpackage

// File: rtl/core/array_list_insert_delete.sv
// Ordered list of CAPACITY signed 32-bit entries in a row of shifting cells.
// Insert, delete, clear, unused codes, failed read/dump: one result, registered next cycle;
// a new item can follow every cycle while the output register drains.
// Read and dump: a walk rotates the occupied cells once, one step per cycle the
// output is free; no item is taken during the walk. Read emits at its position, dump every step.
// Reset clears the count and output control; entry cells hold unknown data until written.
`include "array_list_insert_delete_macros.svh"

module array_list_insert_delete
	import ald_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // func[2:0], position[6:3], value[38:7], zero pad
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // status[1:0], read_value[33:2], list_length[37:34],
	                                      // is_empty[38], zero pad
	output logic               m_tlast
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > 4) ? CW : 4;

	// input fields
	logic [2:0]        in_func;
	logic [3:0]        in_pos;
	logic [DATA_W-1:0] in_value;

	assign in_func  = s_tdata[2:0];
	assign in_pos   = s_tdata[6:3];
	assign in_value = s_tdata[38:7];

	// control state
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;
	logic               walk_q;
	logic               dump_q;
	logic [3:0]         rpos_q;
	logic [IW-1:0]      step_q;
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic               m_tlast_q;

	logic               out_free;
	logic               accept;
	logic               full;
	logic               empty;
	logic [CW-1:0]      tail_full;
	logic [IW-1:0]      tail;
	logic [CMPW-1:0]    cnt_ext;
	logic [CMPW-1:0]    pos_ext;
	logic [CMPW-1:0]    len_ext;
	logic               start_walk;
	logic               single;
	logic [1:0]         st;
	logic               emit;
	logic               walk_last;
	logic               step_done;
	cell_cmd_t          cmd;

	logic [DATA_W-1:0]  entry [CAPACITY];

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = !walk_q && out_free;
	assign accept    = s_tvalid && s_tready;
	assign full      = (cnt_q >= CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign tail_full = cnt_q - 1'b1;
	assign tail      = tail_full[IW-1:0];
	assign cnt_ext   = CMPW'(cnt_q);
	assign pos_ext   = CMPW'(in_pos);
	assign len_ext   = CMPW'(cnt_d);
	assign step_done = (step_q == tail);

	// Decode the accepted item: status, cell command, new count.
	always_comb begin
		cmd.op       = CELL_HOLD;
		cmd.position = walk_q ? rpos_q : in_pos;
		cnt_d        = cnt_q;
		start_walk   = 1'b0;
		single       = 1'b0;
		st           = ST_OK;
		if (accept) begin
			single = 1'b1;
			unique case (in_func)
				FUNC_INSERT: begin
					if (full) begin
						st = ST_FULL;
					end else if (pos_ext > cnt_ext) begin
						st = ST_RANGE;
					end else begin
						cmd.op = CELL_INS;
						cnt_d  = cnt_q + 1'b1;
					end
				end
				FUNC_DELETE: begin
					if (empty) begin
						st = ST_EMPTY;
					end else if (pos_ext >= cnt_ext) begin
						st = ST_RANGE;
					end else begin
						cmd.op = CELL_DEL;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				FUNC_READ: begin
					if (empty) begin
						st = ST_EMPTY;
					end else if (pos_ext >= cnt_ext) begin
						st = ST_RANGE;
					end else begin
						start_walk = 1'b1;
						single     = 1'b0;
					end
				end
				FUNC_CLEAR: begin
					cnt_d = '0;
				end
				FUNC_DUMP: begin
					if (empty) begin
						st = ST_EMPTY;
					end else begin
						start_walk = 1'b1;
						single     = 1'b0;
					end
				end
				default: begin
					st = ST_OK;
				end
			endcase
		end
		// rotate the occupied cells one step per free output slot
		if (walk_q && out_free) begin
			cmd.op = CELL_ROT;
		end
	end

	// Emit from cell 0 during a walk: every step for dump, the addressed step for read.
	assign emit      = walk_q && out_free && (dump_q || (CMPW'(step_q) == CMPW'(rpos_q)));
	assign walk_last = dump_q ? step_done : 1'b1;

	// Build the row of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_val;
		logic [DATA_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = in_value;
		end else begin : g_inner_l
			assign left_val = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_val = entry[i];
		end else begin : g_inner_r
			assign right_val = entry[i+1];
		end

		ald_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.tail      (tail),
			.value     (in_value),
			.left_val  (left_val),
			.right_val (right_val),
			.wrap_val  (entry[0]),
			.entry     (entry[i])
		);
	end

	// Advance the count, the walk and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			walk_q     <= 1'b0;
			dump_q     <= 1'b0;
			rpos_q     <= '0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (start_walk) begin
				walk_q <= 1'b1;
				dump_q <= (in_func == FUNC_DUMP);
				rpos_q <= in_pos;
				step_q <= '0;
			end else if (walk_q && out_free) begin
				if (step_done) begin
					walk_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (single || emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Load the result payload.
	always_ff @(posedge clk) begin
		if (single) begin
			m_tdata_q <= {1'b0, (cnt_d == '0), len_ext[3:0], {DATA_W{1'b0}}, st};
			m_tlast_q <= 1'b1;
		end else if (emit) begin
			m_tdata_q <= {1'b0, 1'b0, cnt_ext[3:0], entry[0], ST_OK};
			m_tlast_q <= walk_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`ALD_ASSERT_IMPL(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`ALD_ASSERT_IMPL(a_no_take_walk, clk, arst_n, walk_q, !s_tready)
	`ALD_ASSERT_IMPL(a_step_in_list, clk, arst_n, walk_q, step_q <= tail && !empty)
	`ALD_ASSERT_NEXT(a_walk_keeps_cnt, clk, arst_n, walk_q, cnt_q == $past(cnt_q))

endmodule

// File: rtl/core/ald_cell.sv
// One storage cell of the ordered list: holds one entry, shifts with its neighbors.
// Depends on ald_pkg for the cell command struct and codes.
module ald_cell
	import ald_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 3
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [IW-1:0]     tail,       // index of the last occupied cell
	input  logic [DATA_W-1:0] value,      // value to insert
	input  logic [DATA_W-1:0] left_val,   // entry of the cell below
	input  logic [DATA_W-1:0] right_val,  // entry of the cell above
	input  logic [DATA_W-1:0] wrap_val,   // entry of cell 0 for rotation
	output logic [DATA_W-1:0] entry
);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] entry_d;

	// Pick the next entry from the broadcast command and this cell's place.
	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			CELL_INS: begin
				if (IDX > int'(cmd.position)) begin
					entry_d = left_val;
				end else if (IDX == int'(cmd.position)) begin
					entry_d = value;
				end
			end
			CELL_DEL: begin
				if (IDX >= int'(cmd.position)) begin
					entry_d = right_val;
				end
			end
			CELL_ROT: begin
				if (IDX < int'(tail)) begin
					entry_d = right_val;
				end else if (IDX == int'(tail)) begin
					entry_d = wrap_val;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule
